/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain property check.
`define RLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define RLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define RLE_ASSERT(lbl, prop, msg)
`define RLE_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

/* sv/rle_pkg.sv */
// ----------------------------------------------------------------------------
// RLE page compressor package
// Constants and the job record passed from the classifier to the serializer.
// ----------------------------------------------------------------------------
package rle_pkg;

    localparam int unsigned MAX_RUN     = 255;
    localparam logic [7:0]  RUN_CAP     = 8'(MAX_RUN);
    localparam logic [7:0]  ESC_BYTE    = 8'hED;
    localparam logic [7:0]  MIN_PACKED  = 8'd4;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned FIFO_DEPTH  = 4;
    localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // What follows the run flush of a job.
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_LIT,
        TAIL_ESC
    } tail_kind_t;

    // One job: an optional run flush, then an optional tail, last marks page end.
    typedef struct packed {
        logic       flush_en;
        logic [7:0] flush_val;
        logic [7:0] flush_len;
        tail_kind_t tail;
        logic [7:0] tail_byte;
        logic       last;
    } job_t;

endpackage

/* sv/rle_front.sv */
// ----------------------------------------------------------------------------
// RLE front end
// Tracks the pending run and turns each accepted byte into at most one job.
// ----------------------------------------------------------------------------
module rle_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output logic          push,
    output rle_pkg::job_t job
);
    import rle_pkg::*;

    logic [7:0] run_value_reg;
    logic [7:0] run_value_next;
    logic [7:0] run_length_reg;
    logic [7:0] run_length_next;
    logic       esc_pend;
    logic       extend;

    always_comb
    begin
        esc_pend = (run_length_reg == 8'd1) && (run_value_reg == ESC_BYTE) &&
                   (data_byte != ESC_BYTE);
        extend   = (run_length_reg != 8'd0) && (data_byte == run_value_reg) &&
                   (run_length_reg < RUN_CAP);

        job.flush_en  = 1'b0;
        job.flush_val = run_value_reg;
        job.flush_len = run_length_reg;
        job.tail      = TAIL_NONE;
        job.tail_byte = data_byte;
        job.last      = last_byte;
        push          = 1'b0;
        run_value_next  = run_value_reg;
        run_length_next = run_length_reg;

        if (esc_pend)
        begin
            // A lone escape drags the next byte out with it as a literal pair.
            job.tail        = TAIL_ESC;
            push            = 1'b1;
            run_length_next = 8'd0;
        end
        else if (extend)
        begin
            run_length_next = run_length_reg + 8'd1;
            if (last_byte)
            begin
                job.flush_en  = 1'b1;
                job.flush_len = run_length_reg + 8'd1;
                push          = 1'b1;
            end
        end
        else
        begin
            job.flush_en    = (run_length_reg != 8'd0);
            job.tail        = last_byte ? TAIL_LIT : TAIL_NONE;
            push            = job.flush_en || last_byte;
            run_value_next  = data_byte;
            run_length_next = 8'd1;
        end

        if (last_byte)
        begin
            run_value_next  = 8'd0;
            run_length_next = 8'd0;
        end

        push = push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= 8'd0;
            run_length_reg <= 8'd0;
        end
        else if (accept)
        begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule

/* sv/rle_fifo.sv */
// ----------------------------------------------------------------------------
// RLE job queue
// Small register queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module rle_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rle_pkg::job_t push_job,
    input  logic          pop,
    output rle_pkg::job_t pop_job,
    output logic          full,
    output logic          empty
);
    import rle_pkg::*;

    job_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;

    assign full    = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* sv/rle_back.sv */
// ----------------------------------------------------------------------------
// RLE back end
// Serializes queued jobs into compressed bytes, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module rle_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rle_pkg::job_t               fifo_job,
    input  logic                        fifo_empty,
    output logic                        pop,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    output logic [rle_pkg::COUNT_W-1:0] byte_count
);
    import rle_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_TAIL
    } stage_t;

    stage_t             stage_reg;
    stage_t             stage_next;
    job_t               job_reg;
    job_t               job_next;
    logic [1:0]         idx_reg;
    logic [1:0]         idx_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         out_byte_reg;
    logic [7:0]         out_byte_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;

    logic               out_free;
    logic               emit;
    logic               packed_run;
    logic [7:0]         cur_byte;
    logic               done;
    logic               job_final;
    logic               load;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign byte_count = byte_count_reg;

    always_comb
    begin
        out_free   = !out_valid_reg || !out_stall;
        emit       = (stage_reg != ST_IDLE) && out_free;
        packed_run = (job_reg.flush_len >= MIN_PACKED) ||
                     ((job_reg.flush_val == ESC_BYTE) && (job_reg.flush_len >= 8'd2));

        cur_byte = 8'd0;
        done     = 1'b0;
        case (stage_reg)
            ST_FLUSH:
            begin
                if (packed_run)
                begin
                    case (idx_reg)
                        2'd0, 2'd1: cur_byte = ESC_BYTE;
                        2'd2:       cur_byte = job_reg.flush_len;
                        default:    cur_byte = job_reg.flush_val;
                    endcase
                    done = (idx_reg == 2'd3);
                end
                else
                begin
                    // Short runs are below four bytes, so two index bits suffice.
                    cur_byte = job_reg.flush_val;
                    done     = (idx_reg == (job_reg.flush_len[1:0] - 2'd1));
                end
            end
            ST_TAIL:
            begin
                if ((job_reg.tail == TAIL_ESC) && (idx_reg == 2'd0))
                begin
                    cur_byte = ESC_BYTE;
                    done     = 1'b0;
                end
                else
                begin
                    cur_byte = job_reg.tail_byte;
                    done     = 1'b1;
                end
            end
            default:
            begin
                cur_byte = 8'd0;
                done     = 1'b0;
            end
        endcase

        job_final = done && ((stage_reg == ST_TAIL) || (job_reg.tail == TAIL_NONE));

        stage_next = stage_reg;
        idx_next   = idx_reg;
        job_next   = job_reg;
        load       = (stage_reg == ST_IDLE);

        if (emit)
        begin
            if (!done)
            begin
                idx_next = idx_reg + 2'd1;
            end
            else if (!job_final)
            begin
                stage_next = ST_TAIL;
                idx_next   = 2'd0;
            end
            else
            begin
                load = 1'b1;
            end
        end

        pop = load && !fifo_empty;
        if (load)
        begin
            if (!fifo_empty)
            begin
                job_next   = fifo_job;
                stage_next = fifo_job.flush_en ? ST_FLUSH : ST_TAIL;
                idx_next   = 2'd0;
            end
            else
            begin
                stage_next = ST_IDLE;
            end
        end

        count_next = count_reg;
        if (emit)
        begin
            count_next = (job_final && job_reg.last) ? '0 : count_reg + 1'b1;
        end

        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        byte_count_next = byte_count_reg;
        if (out_free)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            out_byte_next   = cur_byte;
            out_last_next   = job_final && job_reg.last;
            byte_count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= ST_IDLE;
            job_reg        <= '0;
            idx_reg        <= 2'd0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= 8'd0;
            out_last_reg   <= 1'b0;
            byte_count_reg <= '0;
        end
        else
        begin
            stage_reg      <= stage_next;
            job_reg        <= job_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            byte_count_reg <= byte_count_next;
        end
    end

endmodule

/* sv/rle_ed_escape_page_compressor.sv */
// ----------------------------------------------------------------------------
// RLE page compressor with 0xED escape
// Streaming run-length compressor: one page byte in, zero to five bytes out.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, data_byte, last_byte) moves
// one page byte per transaction; last_byte marks the final byte of a page and
// flushes the pending run. The output channel (out_valid, out_stall, out_byte,
// out_last, byte_count) moves one compressed byte per transaction, with
// byte_count the running compressed size of the page and out_last on its
// final byte. Runs of four or more equal bytes, or two or more 0xED bytes,
// come out as ED ED count value; shorter runs come out as literals.
// Throughput: the front end takes one input transaction per cycle while its
// four-job queue has room; the serializer emits one output byte per cycle
// while not stalled, so sustained rate is set by output bytes per input
// (up to 5/3 on average). A byte that closes a run pushes a job that passes
// through the queue and the serializer's job register to the output register;
// if busy, it also waits for every compressed byte still queued ahead of it.
// Reset clears the run tracker, the queue and the byte count. When the
// receiver stalls, the output byte holds; the queue fills and in_stall rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rle_ed_escape_page_compressor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_byte,
    output logic                        out_last,
    output logic [rle_pkg::COUNT_W-1:0] byte_count
);
    import rle_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;
    job_t push_job;
    job_t pop_job;

    // The queue being full is the only reason to hold off the sender.
    assign in_stall = fifo_full;
    assign accept   = in_valid && !in_stall;

    // Front end: run tracking and job classification.
    rle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .job       (push_job)
    );

    // Job queue between the two halves.
    rle_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // Back end: byte serializer with its output register.
    rle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_job   (pop_job),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .byte_count (byte_count)
    );

    // A job only enters the queue on an accepted transaction.
    `RLE_ASSERT_IMP(a_push_on_accept, push, accept, "job pushed without input transaction")
    // Every last byte of a page produces a job, so the page is always closed.
    `RLE_ASSERT_IMP(a_last_pushes, accept && last_byte, push, "last byte produced no job")
    // The serializer never takes from an empty queue.
    `RLE_ASSERT_IMP(a_pop_nonempty, pop, !fifo_empty, "pop from empty queue")
    // A full queue never takes another job.
    `RLE_ASSERT_IMP(a_no_push_full, fifo_full, !push, "push into full queue")

endmodule
